// ===== hdl/client_activity_lru_table_macros.svh =====
// Assertion macros for the client activity table.
// Included by the top level; no other dependencies.
`ifndef CLIENT_ACTIVITY_LRU_TABLE_MACROS_SVH
`define CLIENT_ACTIVITY_LRU_TABLE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CAL_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define CAL_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== hdl/cal_pkg.sv =====
// Shared types and constants for the client activity table.
// No dependencies.
`timescale 1ns / 1ps
package cal_pkg;
	localparam int TableDepth = 16;
	localparam int IdxW = $clog2(TableDepth);
	localparam int CntW = $clog2(TableDepth + 1);
	localparam int MaxItems = 16;
	localparam int CapW = 5;

	typedef enum logic [1:0] {
		OP_RECORD = 2'd0,
		OP_SNAPSHOT = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef struct packed {
		op_t op;
		logic [7:0] family;
		logic [63:0] ip_upper;
		logic [63:0] ip_lower;
		logic blocked;
		logic [31:0] now_s;
		logic [CapW-1:0] cap;
	} cmd_t;

	typedef struct packed {
		logic [7:0] family;
		logic [63:0] ip_upper;
		logic [63:0] ip_lower;
		logic [31:0] total;
		logic [31:0] blocked;
		logic [31:0] seen;
		logic present;
		logic last;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_EMIT,
		ST_CLEAR
	} state_t;
endpackage

// ===== hdl/cal_front.sv =====
// Front end: accepts requests, classifies the op and queues them (two entries).
// Depends on cal_pkg.
`timescale 1ns / 1ps
module cal_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input cal_pkg::cmd_t in_cmd,
	output logic q_valid,
	input logic q_ready,
	output cal_pkg::cmd_t q_cmd
);
	import cal_pkg::*;
	cmd_t mem_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;
	logic push, pop;

	// Unknown ops are dropped here and never reach the back end.
	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready && (in_cmd.op != OP_NONE);
	assign pop = q_valid && q_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ===== hdl/cal_back.sv =====
// Back end: table, one-entry-per-cycle scan for record and unstalled snapshot.
// Depends on cal_pkg.
`timescale 1ns / 1ps
module cal_back (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_ready,
	input cal_pkg::cmd_t q_cmd,
	output logic out_valid,
	input logic out_ready,
	output cal_pkg::res_t out_res,
	output logic busy
);
	import cal_pkg::*;
	state_t state_q, state_d;
	cmd_t cmd_q;
	logic [TableDepth-1:0] used_q;
	logic [7:0] fam_m [TableDepth];
	logic [63:0] hi_m [TableDepth];
	logic [63:0] lo_m [TableDepth];
	logic [31:0] tot_m [TableDepth];
	logic [31:0] blk_m [TableDepth];
	logic [31:0] seen_m [TableDepth];
	logic [IdxW:0] idx_q;
	logic [IdxW-1:0] ix;
	logic hit_q, free_f_q, old_f_q;
	logic [IdxW-1:0] hit_idx_q, free_idx_q, old_idx_q;
	logic [31:0] old_seen_q;
	logic [CntW-1:0] n_q;
	logic [CapW-1:0] cap;
	logic [CntW-1:0] capn;
	logic match, scan_end, emit_take;
	logic snap_empty, emit_last, emit_fire;
	logic [TableDepth-1:0] above_mask;
	logic [IdxW-1:0] pick;
	res_t emit_res;
	res_t ores_q;
	logic ovalid_q;

	assign ix = idx_q[IdxW-1:0];
	assign cap = (cmd_q.cap > CapW'(MaxItems)) ? CapW'(MaxItems) : cmd_q.cap;
	assign capn = CntW'(cap);
	assign match = used_q[ix] && fam_m[ix] == cmd_q.family &&
		hi_m[ix] == cmd_q.ip_upper && lo_m[ix] == cmd_q.ip_lower;
	assign scan_end = (idx_q == (IdxW+1)'(TableDepth - 1));
	assign pick = hit_q ? hit_idx_q : (free_f_q ? free_idx_q : old_idx_q);
	assign emit_take = !ovalid_q || out_ready;
	// A snapshot with a zero cap or an empty table emits a single marker.
	assign snap_empty = (capn == '0) || (used_q == '0);
	// Entries above the current index; none left in use means this one is the last.
	assign above_mask = ~((TableDepth'(2) << ix) - TableDepth'(1));
	assign emit_last = ((n_q + CntW'(1)) == capn) || !(|(used_q & above_mask));
	assign emit_fire = (state_q == ST_EMIT) && emit_take && (snap_empty || used_q[ix]);
	assign q_ready = (state_q == ST_IDLE);
	assign out_valid = ovalid_q;
	assign out_res = ores_q;
	assign busy = (state_q != ST_IDLE) || ovalid_q;

	always_comb begin
		emit_res = '0;
		if (snap_empty) begin
			emit_res.last = 1'b1;
		end else begin
			emit_res.family = fam_m[ix];
			emit_res.ip_upper = hi_m[ix];
			emit_res.ip_lower = lo_m[ix];
			emit_res.total = tot_m[ix];
			emit_res.blocked = blk_m[ix];
			emit_res.seen = seen_m[ix];
			emit_res.present = 1'b1;
			emit_res.last = emit_last;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					unique case (q_cmd.op)
						OP_RECORD: state_d = ST_SCAN;
						OP_SNAPSHOT: state_d = ST_EMIT;
						default: state_d = ST_CLEAR;
					endcase
				end
			end
			ST_SCAN: if (scan_end || match) state_d = ST_WRITE;
			ST_WRITE: state_d = ST_IDLE;
			ST_EMIT: if (emit_take && (snap_empty || (used_q[ix] && emit_last)))
				state_d = ST_IDLE;
			ST_CLEAR: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			used_q <= '0;
			ovalid_q <= 1'b0;
			idx_q <= '0;
			n_q <= '0;
			hit_q <= 1'b0;
			free_f_q <= 1'b0;
			old_f_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit_fire) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					n_q <= '0;
					hit_q <= 1'b0;
					free_f_q <= 1'b0;
					old_f_q <= 1'b0;
				end
				ST_SCAN: begin
					if (match) begin
						hit_q <= 1'b1;
					end else begin
						if (!used_q[ix] && !free_f_q) free_f_q <= 1'b1;
						if (used_q[ix] && (!old_f_q || seen_m[ix] < old_seen_q))
							old_f_q <= 1'b1;
					end
					idx_q <= idx_q + 1'b1;
				end
				ST_WRITE: used_q[pick] <= 1'b1;
				ST_EMIT: begin
					if (emit_take && !snap_empty) begin
						if (used_q[ix]) n_q <= n_q + 1'b1;
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_CLEAR: used_q <= '0;
				default: ;
			endcase
		end
	end

	// Payload side: command capture, the scan, the table write and the emit path.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) cmd_q <= q_cmd;
		if (state_q == ST_SCAN && !match) begin
			if (!used_q[ix] && !free_f_q) free_idx_q <= ix;
			if (used_q[ix] && (!old_f_q || seen_m[ix] < old_seen_q)) begin
				old_idx_q <= ix;
				old_seen_q <= seen_m[ix];
			end
		end
		if (state_q == ST_SCAN && match) hit_idx_q <= ix;
		if (state_q == ST_WRITE) begin
			if (hit_q) begin
				tot_m[pick] <= tot_m[pick] + 32'd1;
				if (cmd_q.blocked) blk_m[pick] <= blk_m[pick] + 32'd1;
			end else begin
				fam_m[pick] <= cmd_q.family;
				hi_m[pick] <= cmd_q.ip_upper;
				lo_m[pick] <= cmd_q.ip_lower;
				tot_m[pick] <= 32'd1;
				blk_m[pick] <= {31'd0, cmd_q.blocked};
			end
			seen_m[pick] <= cmd_q.now_s;
		end
		if (emit_fire) ores_q <= emit_res;
	end
endmodule

// ===== hdl/client_activity_lru_table.sv =====
// Client activity table, top level: front queue plus back-end table engine.
// Record: the table is scanned one entry per cycle until a match or the last entry,
// then the chosen entry is written. A snapshot walks the entries one per cycle while
// the output is not stalled. The back end takes a new request only when idle.
// Reset: asynchronous, active low; clears the in-use bits and all control.
// Depends on cal_pkg, cal_front, cal_back and the assertion macro header.
`timescale 1ns / 1ps
`include "client_activity_lru_table_macros.svh"
module client_activity_lru_table (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] op,
	input logic [7:0] family,
	input logic [63:0] ip_upper,
	input logic [63:0] ip_lower,
	input logic blocked,
	input logic [31:0] now_s,
	input logic [4:0] snapshot_cap,
	output logic out_valid,
	input logic out_ready,
	output logic [7:0] out_family,
	output logic [63:0] out_ip_upper,
	output logic [63:0] out_ip_lower,
	output logic [31:0] total_queries,
	output logic [31:0] blocked_queries,
	output logic [31:0] last_seen_s,
	output logic entry_present,
	output logic last_item
);
	import cal_pkg::*;
	cmd_t in_cmd, q_cmd;
	res_t res;
	logic q_valid, q_ready, busy;

	// Pack the request fields into one command word for the queue.
	assign in_cmd.op = op_t'(op);
	assign in_cmd.family = family;
	assign in_cmd.ip_upper = ip_upper;
	assign in_cmd.ip_lower = ip_lower;
	assign in_cmd.blocked = blocked;
	assign in_cmd.now_s = now_s;
	assign in_cmd.cap = snapshot_cap;

	cal_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_cmd(in_cmd), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
	);

	// The back end owns the table and drives the registered result port.
	cal_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready),
		.q_cmd(q_cmd), .out_valid(out_valid), .out_ready(out_ready),
		.out_res(res), .busy(busy)
	);

	assign out_family = res.family;
	assign out_ip_upper = res.ip_upper;
	assign out_ip_lower = res.ip_lower;
	assign total_queries = res.total;
	assign blocked_queries = res.blocked;
	assign last_seen_s = res.seen;
	assign entry_present = res.present;
	assign last_item = res.last;

	// An empty-snapshot result must also be the last one.
	`CAL_ASSERT_IMP(a_empty_last, out_valid && !entry_present, last_item)
	// A result is only shown while the back end is busy with it.
	`CAL_ASSERT_IMP(a_out_busy, out_valid, busy)
	// A request taken from the queue is always followed by the back end going busy.
	`CAL_ASSERT_NXT(a_take_busy, q_valid && q_ready, busy)
endmodule
